[hdl/sra_pkg.sv]
// Shared constants, codes and controller/datapath interface types
// for the segment range allocator. No dependencies.
`default_nettype none
package sra_pkg;

    localparam int FREE_SLOTS = 16;
    localparam int SLOT_BITS  = $clog2(FREE_SLOTS);
    localparam int CNT_BITS   = $clog2(FREE_SLOTS + 1);
    localparam int SEG_IDS    = 64;
    localparam int ID_BITS    = $clog2(SEG_IDS);
    localparam int ADDR_BITS  = 16;
    localparam int LEN_BITS   = ADDR_BITS + 1;
    localparam int END_BITS   = ADDR_BITS + 2;
    localparam int ST_BITS    = 2;
    localparam int IN_BITS    = 1 + ID_BITS + ADDR_BITS + LEN_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BYTES  = (ST_BITS + 7) / 8;

    localparam logic [LEN_BITS-1:0] SPACE_MAX = LEN_BITS'(1) << ADDR_BITS;

    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [ST_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [ST_BITS-1:0] ST_NOFIT   = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_BITS-1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic commit;
        logic init;
    } sra_cmd_t;

    typedef struct packed {
        logic               stop;
        logic [ST_BITS-1:0] result;
    } sra_stat_t;

endpackage
`default_nettype wire

[hdl/sra_ctrl.sv]
// Controller state machine of the segment range allocator: sequencing,
// handshakes and result register. Depends on sra_pkg.
`default_nettype none
module sra_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sra_pkg::ST_BITS-1:0]        m_status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    output sra_pkg::sra_cmd_t                  cmd,
    input  wire sra_pkg::sra_stat_t            stat
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    logic [sra_pkg::ST_BITS-1:0] out_status_reg, out_status_next;
    logic                        resp_fire;

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_status  = out_status_reg;
    assign resp_fire = (state_reg == S_RESP) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.commit  = 1'b0;
        cmd.init    = cfg_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.stop)
                    state_next = S_COMMIT;
                else
                    cmd.step = 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (resp_fire)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (resp_fire)
        begin
            out_valid_next  = 1'b1;
            out_status_next = stat.result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= sra_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule
`default_nettype wire

[hdl/sra_datapath.sv]
// Datapath of the segment range allocator: free range table, scan pointer,
// segment record memory and live bits. Depends on sra_pkg.
`default_nettype none
module sra_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [sra_pkg::IN_BITS-1:0]    in_item,
    input  wire logic [sra_pkg::LEN_BITS-1:0]   cfg_words,
    input  wire sra_pkg::sra_cmd_t              cmd,
    output sra_pkg::sra_stat_t                  stat
);

    localparam int N  = sra_pkg::FREE_SLOTS;
    localparam int CB = sra_pkg::CNT_BITS;
    localparam int AB = sra_pkg::ADDR_BITS;
    localparam int LB = sra_pkg::LEN_BITS;
    localparam int EB = sra_pkg::END_BITS;
    localparam int IB = sra_pkg::ID_BITS;

    logic [AB-1:0] fbase_reg [N];
    logic [LB-1:0] flen_reg  [N];
    logic [AB-1:0] fbase_next [N];
    logic [LB-1:0] flen_next  [N];
    logic [CB-1:0] count_reg, count_next;
    logic [sra_pkg::SEG_IDS-1:0] live_reg, live_next;

    logic [AB-1:0] seg_base_mem [sra_pkg::SEG_IDS];
    logic [LB-1:0] seg_len_mem  [sra_pkg::SEG_IDS];
    logic [AB-1:0] rd_base_reg;
    logic [LB-1:0] rd_len_reg;

    logic          op_reg;
    logic [IB-1:0] id_reg;
    logic [AB-1:0] b_reg;
    logic [LB-1:0] l_reg;
    logic [CB-1:0] ptr_reg;
    logic [EB-1:0] prev_end_reg;
    logic [AB-1:0] prev_base_reg;
    logic [LB-1:0] prev_len_reg;
    logic [sra_pkg::ST_BITS-1:0] res_reg, res_next;

    logic          in_op;
    logic [IB-1:0] in_id;
    logic [AB-1:0] in_base;
    logic [LB-1:0] in_len;

    logic          in_range;
    logic [AB-1:0] cur_base;
    logic [LB-1:0] cur_len;
    logic [EB-1:0] cur_end, req_end;
    logic          covers, hit, left_adj, right_adj, full, rec_wr;
    logic          wr_en, sh_left, sh_right;
    logic [CB-1:0] wr_idx, sh_idx;
    logic [AB-1:0] wr_b, ins_b;
    logic [LB-1:0] wr_l, ins_l;
    logic [LB-1:0] init_len;

    assign in_op   = in_item[0];
    assign in_id   = in_item[IB:1];
    assign in_base = in_item[IB+AB:IB+1];
    assign in_len  = in_item[IB+AB+LB:IB+AB+1];

    assign in_range = ptr_reg < count_reg;
    assign cur_base = fbase_reg[ptr_reg[sra_pkg::SLOT_BITS-1:0]];
    assign cur_len  = flen_reg[ptr_reg[sra_pkg::SLOT_BITS-1:0]];
    assign cur_end  = {2'b00, cur_base} + {1'b0, cur_len};
    assign req_end  = {2'b00, b_reg} + {1'b0, l_reg};
    assign covers   = (cur_base <= b_reg) && (cur_end >= req_end);
    assign hit      = in_range && covers;
    assign full     = count_reg >= CB'(N);
    assign left_adj  = (ptr_reg != '0) && (prev_end_reg == {2'b00, b_reg});
    assign right_adj = in_range && ({2'b00, cur_base} == req_end);

    assign stat.stop   = (op_reg == sra_pkg::OP_CREATE) ? (!in_range || covers)
                                                       : (!in_range || cur_end > {2'b00, b_reg});
    assign stat.result = res_reg;

    always_comb
    begin
        init_len = cfg_words;
        if (cfg_words == '0)
            init_len = LB'(1);
        else if (cfg_words > sra_pkg::SPACE_MAX)
            init_len = sra_pkg::SPACE_MAX;
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = ptr_reg;
        wr_b     = cur_base;
        wr_l     = cur_len;
        sh_left  = 1'b0;
        sh_right = 1'b0;
        sh_idx   = ptr_reg;
        ins_b    = b_reg;
        ins_l    = l_reg;
        rec_wr   = 1'b0;
        res_next = sra_pkg::ST_OK;
        count_next = count_reg;
        live_next  = live_reg;
        if (op_reg == sra_pkg::OP_CREATE)
        begin
            if (l_reg == '0 || !hit)
                res_next = sra_pkg::ST_NOFIT;
            else if (b_reg == cur_base)
            begin
                if (req_end == cur_end)
                begin
                    sh_left    = 1'b1;
                    count_next = count_reg - CB'(1);
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_b  = req_end[AB-1:0];
                    wr_l  = LB'(cur_end - req_end);
                end
            end
            else if (req_end == cur_end)
            begin
                wr_en = 1'b1;
                wr_l  = LB'(b_reg - cur_base);
            end
            else if (full)
                res_next = sra_pkg::ST_FULL;
            else
            begin
                wr_en      = 1'b1;
                wr_l       = LB'(b_reg - cur_base);
                sh_right   = 1'b1;
                sh_idx     = ptr_reg + CB'(1);
                ins_b      = req_end[AB-1:0];
                ins_l      = LB'(cur_end - req_end);
                count_next = count_reg + CB'(1);
            end
            if (res_next == sra_pkg::ST_OK)
            begin
                rec_wr            = 1'b1;
                live_next[id_reg] = 1'b1;
            end
        end
        else
        begin
            if (!live_reg[id_reg])
                res_next = sra_pkg::ST_UNKNOWN;
            else if (left_adj && right_adj)
            begin
                wr_en      = 1'b1;
                wr_idx     = ptr_reg - CB'(1);
                wr_b       = prev_base_reg;
                wr_l       = LB'({1'b0, prev_len_reg} + {1'b0, l_reg} + {1'b0, cur_len});
                sh_left    = 1'b1;
                count_next = count_reg - CB'(1);
            end
            else if (left_adj)
            begin
                wr_en  = 1'b1;
                wr_idx = ptr_reg - CB'(1);
                wr_b   = prev_base_reg;
                wr_l   = prev_len_reg + l_reg;
            end
            else if (right_adj)
            begin
                wr_en = 1'b1;
                wr_b  = b_reg;
                wr_l  = cur_len + l_reg;
            end
            else if (full)
                res_next = sra_pkg::ST_FULL;
            else
            begin
                sh_right   = 1'b1;
                count_next = count_reg + CB'(1);
            end
            if (res_next == sra_pkg::ST_OK)
                live_next[id_reg] = 1'b0;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_slot
        logic [AB-1:0] up_b, dn_b;
        logic [LB-1:0] up_l, dn_l;
        if (k < N - 1)
        begin : g_up
            assign up_b = fbase_reg[k+1];
            assign up_l = flen_reg[k+1];
        end
        else
        begin : g_top
            assign up_b = '0;
            assign up_l = '0;
        end
        if (k > 0)
        begin : g_dn
            assign dn_b = fbase_reg[k-1];
            assign dn_l = flen_reg[k-1];
        end
        else
        begin : g_bot
            assign dn_b = '0;
            assign dn_l = '0;
        end
        always_comb
        begin
            fbase_next[k] = fbase_reg[k];
            flen_next[k]  = flen_reg[k];
            if (sh_left && CB'(k) >= sh_idx)
            begin
                fbase_next[k] = up_b;
                flen_next[k]  = up_l;
            end
            if (sh_right && CB'(k) > sh_idx)
            begin
                fbase_next[k] = dn_b;
                flen_next[k]  = dn_l;
            end
            if (sh_right && CB'(k) == sh_idx)
            begin
                fbase_next[k] = ins_b;
                flen_next[k]  = ins_l;
            end
            if (wr_en && CB'(k) == wr_idx)
            begin
                fbase_next[k] = wr_b;
                flen_next[k]  = wr_l;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbase_reg[0] <= '0;
            flen_reg[0]  <= sra_pkg::SPACE_MAX;
            for (int k = 1; k < N; k++)
            begin
                fbase_reg[k] <= '0;
                flen_reg[k]  <= '0;
            end
            count_reg   <= CB'(1);
            live_reg    <= '0;
            res_reg     <= sra_pkg::ST_OK;
            ptr_reg     <= '0;
        end
        else if (cmd.init)
        begin
            fbase_reg[0] <= '0;
            flen_reg[0]  <= init_len;
            count_reg    <= CB'(1);
            live_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            for (int k = 0; k < N; k++)
            begin
                fbase_reg[k] <= fbase_next[k];
                flen_reg[k]  <= flen_next[k];
            end
            count_reg <= count_next;
            live_reg  <= live_next;
            res_reg   <= res_next;
        end
        else if (cmd.load)
            ptr_reg <= '0;
        else if (cmd.step)
            ptr_reg <= ptr_reg + CB'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op;
            id_reg <= in_id;
            b_reg  <= in_base;
            l_reg  <= in_len;
        end
        else if (cmd.load && op_reg == sra_pkg::OP_REMOVE)
        begin
            b_reg <= rd_base_reg;
            l_reg <= rd_len_reg;
        end
        if (cmd.load)
        begin
            prev_end_reg  <= '0;
            prev_base_reg <= '0;
            prev_len_reg  <= '0;
        end
        else if (cmd.step)
        begin
            prev_end_reg  <= cur_end;
            prev_base_reg <= cur_base;
            prev_len_reg  <= cur_len;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_base_reg <= seg_base_mem[in_id];
        rd_len_reg  <= seg_len_mem[in_id];
        if (cmd.commit && rec_wr)
        begin
            seg_base_mem[id_reg] <= b_reg;
            seg_len_mem[id_reg]  <= l_reg;
        end
    end

endmodule
`default_nettype wire

[hdl/segment_range_allocator.sv]
// Sequence: capture of the input transaction, load, then a scan of up to
// FREE_SLOTS free entries, one entry per cycle, then one table update and the result.
// Throughput: one request in flight at a time; the next is taken once the
// result is registered. Reset: free table holds one range of 65536 words,
// all segment records dead. Top level; depends on sra_pkg, sra_ctrl, sra_datapath.
`default_nettype none
module segment_range_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // op[0], seg_id[6:1], base_addr[22:7], length[39:23]
    input  wire logic [8*sra_pkg::IN_BYTES-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], zero above
    output logic [8*sra_pkg::OUT_BYTES-1:0]        m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sra_pkg::LEN_BITS-1:0]      cfg_data
);

    sra_pkg::sra_cmd_t           cmd;
    sra_pkg::sra_stat_t          stat;
    logic [sra_pkg::ST_BITS-1:0] status;

    sra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_status  (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sra_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (s_tdata[sra_pkg::IN_BITS-1:0]),
        .cfg_words (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = {{(8*sra_pkg::OUT_BYTES-sra_pkg::ST_BITS){1'b0}}, status};

endmodule
`default_nettype wire

[hdl/sra_checker.sv]
// Port-level checker for the segment range allocator, bound to the top level.
// Depends on sra_pkg and segment_range_allocator.
`default_nettype none
module sra_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [8*sra_pkg::OUT_BYTES-1:0]   m_tdata,
    input  wire logic                              cfg_ready
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !cfg_ready)
        else $error("configuration ready while a request is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[8*sra_pkg::OUT_BYTES-1:sra_pkg::ST_BITS] == '0)
        else $error("result padding not zero");

endmodule

bind segment_range_allocator sra_checker u_sra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
